// ===== sv/event_flag_mailbox_core_assert.svh =====
// Assertion macros shared by the mailbox RTL.
`ifndef EVENT_FLAG_MAILBOX_CORE_ASSERT_SVH
`define EVENT_FLAG_MAILBOX_CORE_ASSERT_SVH

// Checked only outside reset.
`define EFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define EFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== sv/efm_pkg.sv =====
package efm_pkg;

  // Fixed field widths
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned PVALUE_W    = 32;
  localparam int unsigned PARAM_OUT_W = 32;

  // Default sizes
  localparam int unsigned POINT_COUNT_DEF = 32;
  localparam int unsigned BCAST_COUNT_DEF = 16;
  localparam int unsigned PARAM_BITS_DEF  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK       = 3'd0,
    MODE_SEND       = 3'd1,
    MODE_GET        = 3'd2,
    MODE_SEND_PARAM = 3'd3,
    MODE_READ_PARAM = 3'd4,
    MODE_BSEND      = 3'd5,
    MODE_BGET       = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    FLAG_IDLE    = 2'd0,
    FLAG_POSTED  = 2'd1,
    FLAG_VISIBLE = 2'd2
  } flag_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_e;

  // One tick: posted -> visible -> idle
  function automatic flag_e advance_flag(flag_e f);
    flag_e r;
    case (f)
      FLAG_POSTED:  r = FLAG_VISIBLE;
      FLAG_VISIBLE: r = FLAG_IDLE;
      default:      r = FLAG_IDLE;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/efm_in_if.sv =====
interface efm_in_if
  import efm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [INDEX_W-1:0]  index;
  logic [PVALUE_W-1:0] param_value;

  modport source (output valid, mode, index, param_value, input ready);
  modport sink   (input valid, mode, index, param_value, output ready);
endinterface

// ===== sv/efm_out_if.sv =====
interface efm_out_if
  import efm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   got_message;
  logic [PARAM_OUT_W-1:0] param_out;
  logic                   index_error;

  modport source (output valid, got_message, param_out, index_error, input ready);
  modport sink   (input valid, got_message, param_out, index_error, output ready);
endinterface

// ===== sv/event_flag_mailbox_core.sv =====
// Channel | Dir | Transfer carries
// --------+-----+-------------------------------------------
// in_i    | in  | mode, index, param_value (one command)
// out_o   | out | got_message, param_out, index_error
//
// Each command has a transfer cycle, in which the flags update and the
// parameter RAM is accessed; the next cycle the registered RAM read data is
// folded into the output register. No new command is taken while one is being finished.
// Reset clears all flags and parameter written bits at once; no sweep.
// A stalled result holds in the output register; input waits until the
// sequencer is idle and the output slot is free or being drained.
module event_flag_mailbox_core
  import efm_pkg::*;
#(
  parameter int unsigned POINT_COUNT = POINT_COUNT_DEF,
  parameter int unsigned BCAST_COUNT = BCAST_COUNT_DEF,
  parameter int unsigned PARAM_BITS  = PARAM_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  efm_in_if.sink    in_i,
  efm_out_if.source out_o
);
  `include "event_flag_mailbox_core_assert.svh"

  localparam int unsigned PW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int unsigned BW = (BCAST_COUNT > 1) ? $clog2(BCAST_COUNT) : 1;

  state_e state_q, state_d;
  flag_e  pflags_q [POINT_COUNT];
  flag_e  pflags_d [POINT_COUNT];
  flag_e  bflags_q [BCAST_COUNT];
  flag_e  bflags_d [BCAST_COUNT];
  logic [POINT_COUNT-1:0] pwritten_q, pwritten_d;

  logic got_q, err_q, rd_q, rd_vld_q;
  logic out_valid_q;
  logic got_out_q, err_out_q;
  logic [PARAM_OUT_W-1:0] pout_q;

  logic in_xfer;
  mode_e mode;
  logic [PW-1:0] pidx;
  logic [BW-1:0] bidx;
  logic pok, bok;
  flag_e psel, bsel;
  logic ram_we, ram_re;
  logic [PARAM_BITS-1:0] ram_wdata, ram_rdata;
  logic got_d, err_d;

  // Decode the command
  assign mode    = mode_e'(in_i.mode);
  assign pidx    = in_i.index[PW-1:0];
  assign bidx    = in_i.index[BW-1:0];
  assign pok     = {1'b0, in_i.index} < (INDEX_W+1)'(POINT_COUNT);
  assign bok     = {1'b0, in_i.index} < (INDEX_W+1)'(BCAST_COUNT);
  assign psel    = pok ? pflags_q[pidx] : FLAG_IDLE;
  assign bsel    = bok ? bflags_q[bidx] : FLAG_IDLE;
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_xfer = in_i.valid && in_i.ready;

  // Sequencer: take a command, then finish it
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_BUSY;
      ST_BUSY: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Flag tables, parameter writes and the per-command status bits
  always_comb begin
    pflags_d   = pflags_q;
    bflags_d   = bflags_q;
    pwritten_d = pwritten_q;
    got_d      = 1'b0;
    err_d      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (in_xfer) begin
      case (mode)
        MODE_TICK: begin
          for (int i = 0; i < POINT_COUNT; i++) pflags_d[i] = advance_flag(pflags_q[i]);
          for (int i = 0; i < BCAST_COUNT; i++) bflags_d[i] = advance_flag(bflags_q[i]);
        end
        MODE_SEND, MODE_SEND_PARAM: begin
          if (!pok) begin
            err_d = 1'b1;
          end else if (psel == FLAG_IDLE) begin
            pflags_d[pidx] = FLAG_POSTED;
            if (mode == MODE_SEND_PARAM) begin
              ram_we           = 1'b1;
              pwritten_d[pidx] = 1'b1;
            end
          end
        end
        MODE_GET: begin
          if (!pok) begin
            err_d = 1'b1;
          end else if (psel == FLAG_VISIBLE) begin
            pflags_d[pidx] = FLAG_IDLE;
            got_d          = 1'b1;
          end
        end
        MODE_READ_PARAM: begin
          if (!pok) err_d = 1'b1;
          else ram_re = 1'b1;
        end
        MODE_BSEND: begin
          if (!bok) begin
            err_d = 1'b1;
          end else if (bsel == FLAG_IDLE) begin
            bflags_d[bidx] = FLAG_POSTED;
          end
        end
        MODE_BGET: begin
          if (!bok) err_d = 1'b1;
          else got_d = (bsel == FLAG_VISIBLE);
        end
        MODE_CLEAR: begin
          for (int i = 0; i < POINT_COUNT; i++) pflags_d[i] = FLAG_IDLE;
          for (int i = 0; i < BCAST_COUNT; i++) bflags_d[i] = FLAG_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POINT_COUNT; i++) pflags_q[i] <= FLAG_IDLE;
      for (int i = 0; i < BCAST_COUNT; i++) bflags_q[i] <= FLAG_IDLE;
      pwritten_q <= '0;
    end else begin
      pflags_q   <= pflags_d;
      bflags_q   <= bflags_d;
      pwritten_q <= pwritten_d;
    end
  end

  // Parameter words; never-written entries read as zero
  assign ram_wdata = PARAM_BITS'(in_i.param_value);

  efm_ram #(
    .WIDTH (PARAM_BITS),
    .DEPTH (POINT_COUNT)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pidx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pidx),
    .rdata_o (ram_rdata)
  );

  // Status carried alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      got_q    <= got_d;
      err_q    <= err_d;
      rd_q     <= ram_re;
      rd_vld_q <= pok && pwritten_q[pidx];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_BUSY) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BUSY) begin
      got_out_q <= got_q;
      err_out_q <= err_q;
      pout_q    <= (rd_q && rd_vld_q) ? PARAM_OUT_W'(ram_rdata) : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.got_message = got_out_q;
  assign out_o.param_out   = pout_q;
  assign out_o.index_error = err_out_q;

  // Finishing a command never lands on a result still waiting
  `EFM_ASSERT(a_no_overwrite, (state_q == ST_BUSY) |-> (!out_valid_q || out_o.ready), "result overwritten")
  // A new result appears only after a command was worked on
  `EFM_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(state_q == ST_BUSY), "spurious result")
  // An unwritten parameter entry reads back as zero
  `EFM_ASSERT(a_unwritten_zero, (state_q == ST_BUSY && rd_q && !rd_vld_q) |=> (pout_q == '0), "stale param")
  // Reset leaves the sequencer idle with no result pending
  `EFM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (state_q == ST_IDLE && !out_valid_q), "reset state")
endmodule

// ===== sv/efm_ram.sv =====
module efm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
